### rtl/core/mipsp_pkg.sv
// Package: transaction types, opcode constants and instruction field decode for the pipeline core.
package mipsp_pkg;

    // Transaction modes
    localparam logic [1:0] MODE_IMEM = 2'd0;
    localparam logic [1:0] MODE_DMEM = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    // Primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2b;

    // SPECIAL function codes
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLTU = 6'h2b;

    localparam logic [4:0] REG_RA = 5'd31;

    typedef struct packed {
        logic [1:0]  mode;
        logic [9:0]  word_index;
        logic [31:0] word_value;
    } t_in;

    typedef struct packed {
        logic        retire_valid;
        logic [31:0] retire_pc;
        logic        store_valid;
        logic [31:0] store_address;
        logic [31:0] store_value;
        logic        halted;
    } t_out;

    typedef struct packed {
        logic [5:0]  op;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [5:0]  fn;
        logic [31:0] imm;
        logic [25:0] tgt;
    } t_fields;

    // Split an instruction word; fields that the format lacks read as zero
    function automatic t_fields decode_instr(input logic [31:0] w);
        t_fields f;
        f = '0;
        f.op = w[31:26];
        if (f.op == OP_SPECIAL || f.op > OP_JAL) begin
            f.rs = w[25:21];
            f.rt = w[20:16];
            if (f.op == OP_SPECIAL) begin
                f.rd = w[15:11];
                f.sh = w[10:6];
                f.fn = w[5:0];
            end else if (f.op == OP_ANDI || f.op == OP_ORI || f.op == OP_LUI) begin
                f.imm = {16'h0000, w[15:0]};
            end else begin
                f.imm = {{16{w[15]}}, w[15:0]};
            end
        end else begin
            f.tgt = w[25:0];
        end
        return f;
    endfunction

endpackage

### rtl/core/mips_subset_five_stage_pipeline_core.sv
// Top level: five-stage integer pipeline core with instruction and data memories.
//
// Input channel (i_in_valid / o_in_ready, payload t_in): each transaction is a
// load (mode 0 writes an instruction word, mode 1 a data word) or a tick
// (mode 2) that advances the pipeline one step unless halted. Mode 3 is ignored.
// Output channel (o_out_valid / i_out_ready, payload t_out): one result per
// tick with the retiring PC, any store word and the halted flag; loads give
// no result.
// Configuration: i_cfg_we writes program_length from i_cfg_wdata at once.
// A tick's result shows in the output register in the cycle after the
// transaction is accepted. Throughput: one transaction per cycle while o_in_ready
// is high; the whole pipeline step is one pass of logic between the state
// registers and the result register, with the next MEM data read prefetched.
// Reset: all latches, register file and flags clear; the data memory is
// swept to zero one word per cycle, so o_in_ready stays low after reset
// until every word is cleared.
// Stall: while the result register is full and i_out_ready is low, o_in_ready
// is low; nothing is lost or repeated.
module mips_subset_five_stage_pipeline_core
    import mipsp_pkg::*;
#(
    parameter int unsigned IMEM_DEPTH = 1024,
    parameter int unsigned DMEM_DEPTH = 1024,
    parameter logic [31:0] TEXT_BASE  = 32'h0040_0000
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata
);

    localparam int unsigned IAW = $clog2(IMEM_DEPTH);
    localparam int unsigned DAW = $clog2(DMEM_DEPTH);
    localparam logic [DAW-1:0] DLAST = DAW'(DMEM_DEPTH - 1);

    // Memories
    logic [31:0] r_imem [IMEM_DEPTH];
    logic [31:0] r_dmem [DMEM_DEPTH];
    logic [31:0] r_rf   [32];

    // Pipeline state
    logic [4:0]  r_sv, n_sv;
    logic [31:0] r_sp [5];
    logic [31:0] n_sp [5];
    logic [31:0] r_si [1:4];
    logic [31:0] n_si [1:4];
    logic [31:0] r_pc, n_pc;
    logic [31:0] r_if_rdata, r_dm_rdata;
    logic [31:0] r_de_a, n_de_a, r_de_b, n_de_b, r_de_imm, n_de_imm;
    logic [4:0]  r_de_dest, n_de_dest;
    logic [31:0] r_ex_alu, n_ex_alu, r_ex_target, n_ex_target, r_ex_addr, n_ex_addr;
    logic        r_ex_take, n_ex_take;
    logic [4:0]  r_ex_dest, n_ex_dest;
    logic [4:0]  r_mw_dest, n_mw_dest;
    logic [31:0] r_mw_out, n_mw_out;
    logic [4:0]  r_fw_ex_reg, n_fw_ex_reg, r_fw_mem_reg, n_fw_mem_reg;
    logic [31:0] r_fw_ex_val, n_fw_ex_val, r_fw_mem_val, n_fw_mem_val;
    logic        r_stall, n_stall, r_halted, n_halted;
    logic [10:0] r_plen;
    logic        r_clr_busy;
    logic [DAW-1:0] r_clr_idx;
    logic        r_out_valid;
    t_out        r_out, n_out;

    // Handshake
    logic w_acc, w_tick, w_res;
    assign o_in_ready = !r_clr_busy && (!r_out_valid || i_out_ready);
    assign w_acc  = i_in_valid && o_in_ready;
    assign w_res  = w_acc && (i_in_data.mode == MODE_TICK);
    assign w_tick = w_res && !r_halted;

    // Register file and memory write controls
    logic           w_wb_we, w_jal_we, w_st_we, w_im_we, w_dm_we;
    logic [31:0]    w_jal_data, w_st_data, w_dm_wdata;
    logic [DAW-1:0] w_dm_waddr, w_dm_raddr, w_ld_didx;
    logic [IAW-1:0] w_im_raddr, w_ld_iidx;
    logic [31:0]    w_ld_wide;
    t_fields        f1, f2, f3, f4;
    logic [31:0]    w_a, w_b, w_off, w_off4;
    logic           w_flush, w_jump, w_load_use;
    logic [31:0]    w_jump_pc, w_seq_pc;

    function automatic logic [IAW-1:0] imem_idx(input logic [31:0] pc);
        logic [31:0] off;
        off = pc - TEXT_BASE;
        return off[IAW+1:2];
    endfunction

    assign w_ld_wide = {22'd0, i_in_data.word_index};
    assign w_ld_iidx = w_ld_wide[IAW-1:0];
    assign w_ld_didx = w_ld_wide[DAW-1:0];
    assign w_im_we   = w_acc && (i_in_data.mode == MODE_IMEM);

    // One pipeline step
    always_comb begin
        n_sv = r_sv;
        n_sp = r_sp;
        n_si = r_si;
        n_pc = r_pc;
        n_de_a = r_de_a; n_de_b = r_de_b; n_de_imm = r_de_imm; n_de_dest = r_de_dest;
        n_ex_alu = r_ex_alu; n_ex_target = r_ex_target; n_ex_addr = r_ex_addr;
        n_ex_take = r_ex_take; n_ex_dest = r_ex_dest;
        n_mw_dest = r_mw_dest; n_mw_out = r_mw_out;
        n_fw_ex_reg = r_fw_ex_reg; n_fw_ex_val = r_fw_ex_val;
        n_fw_mem_reg = r_fw_mem_reg; n_fw_mem_val = r_fw_mem_val;
        n_stall = r_stall;
        n_halted = r_halted;
        n_out = '0;
        n_out.halted = r_halted;
        w_wb_we = 1'b0; w_jal_we = 1'b0; w_jal_data = '0;
        w_st_we = 1'b0; w_st_data = '0;
        w_flush = 1'b0; w_jump = 1'b0; w_jump_pc = '0; w_load_use = 1'b0;
        w_seq_pc = '0;
        w_a = '0; w_b = '0; w_off = '0; w_off4 = '0;
        f1 = '0; f2 = '0; f3 = '0; f4 = '0;

        // Instruction loads patch the words carried down the pipeline
        if (w_im_we) begin
            for (int k = 1; k <= 4; k++) begin
                if (imem_idx(r_sp[k]) == w_ld_iidx) n_si[k] = i_in_data.word_value;
            end
        end

        if (w_tick) begin
            // Advance stages; a stall holds IF and ID and leaves a bubble in EX
            n_sv[4] = r_sv[3]; n_sp[4] = r_sp[3]; n_si[4] = r_si[3];
            n_sv[3] = r_sv[2]; n_sp[3] = r_sp[2]; n_si[3] = r_si[2];
            if (r_stall) begin
                n_sv[2] = 1'b0; n_sp[2] = '0;
            end else begin
                n_sv[2] = r_sv[1]; n_sp[2] = r_sp[1]; n_si[2] = r_si[1];
                n_sv[1] = r_sv[0]; n_sp[1] = r_sp[0]; n_si[1] = r_if_rdata;
                n_sv[0] = 1'b0;    n_sp[0] = '0;
            end
            n_stall = 1'b0;
            f4 = decode_instr(n_si[4]);
            f3 = decode_instr(n_si[3]);

            // Write back
            if (n_sv[4]) begin
                n_out.retire_valid = 1'b1;
                n_out.retire_pc    = n_sp[4];
                w_wb_we = ((f4.op == OP_SPECIAL && f4.fn != FN_JR) ||
                           (f4.op inside {[6'h06:6'h24]})) && (r_mw_dest != 5'd0);
            end

            // Memory
            if (!n_sv[3]) begin
                n_mw_dest = '0;
                n_mw_out  = '0;
            end else begin
                n_mw_dest = r_ex_dest;
                n_mw_out  = r_ex_alu;
                if (r_ex_take) begin
                    w_flush = 1'b1;
                    n_sv[1] = 1'b0; n_sp[1] = '0;
                    n_sv[2] = 1'b0; n_sp[2] = '0;
                end
                if (f3.op == OP_LW) n_mw_out = r_dm_rdata;
                if (f3.op == OP_SW) begin
                    if (f3.rt != 5'd0) begin
                        if (r_fw_mem_reg == f3.rt) w_st_data = r_fw_mem_val;
                        else if (w_wb_we && r_mw_dest == f3.rt) w_st_data = r_mw_out;
                        else w_st_data = r_rf[f3.rt];
                    end
                    w_st_we = 1'b1;
                    n_out.store_valid   = 1'b1;
                    n_out.store_address = r_ex_addr;
                    n_out.store_value   = w_st_data;
                end
            end

            // Execute, with forwarding from the EX/MEM and MEM/WB results
            f2 = decode_instr(n_si[2]);
            if (!n_sv[2]) begin
                n_ex_alu = '0; n_ex_take = 1'b0; n_ex_target = '0;
                n_ex_dest = '0; n_ex_addr = '0;
            end else begin
                if (f2.rs == 5'd0) w_a = '0;
                else if (r_fw_ex_reg == f2.rs) w_a = r_fw_ex_val;
                else if (r_fw_mem_reg == f2.rs) w_a = r_fw_mem_val;
                else w_a = r_de_a;
                if (f2.rt == 5'd0) w_b = '0;
                else if (r_fw_ex_reg == f2.rt) w_b = r_fw_ex_val;
                else if (r_fw_mem_reg == f2.rt) w_b = r_fw_mem_val;
                else w_b = r_de_b;
                n_ex_take = 1'b0;
                case (f2.op)
                    OP_ADDIU: n_ex_alu = w_a + r_de_imm;
                    OP_ANDI:  n_ex_alu = w_a & r_de_imm;
                    OP_LUI:   n_ex_alu = {r_de_imm[15:0], 16'h0000};
                    OP_ORI:   n_ex_alu = w_a | r_de_imm;
                    OP_SLTIU: n_ex_alu = {31'd0, w_a < r_de_imm};
                    OP_BEQ: begin
                        n_ex_target = n_sp[2] + {r_de_imm[29:0], 2'b00} + 32'd4;
                        n_ex_take   = (w_a == w_b);
                    end
                    OP_BNE: begin
                        n_ex_target = n_sp[2] + {r_de_imm[29:0], 2'b00} + 32'd4;
                        n_ex_take   = (w_a != w_b);
                    end
                    OP_SPECIAL: begin
                        case (f2.fn)
                            FN_SLL:  n_ex_alu = w_b << r_de_imm[4:0];
                            FN_SRL:  n_ex_alu = w_b >> r_de_imm[4:0];
                            FN_JR: begin
                                n_sv[1] = 1'b0; n_sp[1] = '0;
                            end
                            FN_ADDU: n_ex_alu = w_a + w_b;
                            FN_SUBU: n_ex_alu = w_a - w_b;
                            FN_AND:  n_ex_alu = w_a & w_b;
                            FN_OR:   n_ex_alu = w_a | w_b;
                            FN_NOR:  n_ex_alu = ~(w_a | w_b);
                            FN_SLTU: n_ex_alu = {31'd0, w_a < w_b};
                            default: ;
                        endcase
                    end
                    OP_J, OP_JAL: begin
                        n_sv[1] = 1'b0; n_sp[1] = '0;
                    end
                    OP_LW, OP_SW: n_ex_addr = w_a + r_de_imm;
                    default: ;
                endcase
                n_ex_dest = r_de_dest;
            end

            // Decode, with load-use stall and jump resolution
            f1 = decode_instr(n_si[1]);
            n_de_dest = '0;
            if (!n_sv[1]) begin
                n_de_a = '0; n_de_b = '0; n_de_imm = '0;
            end else begin
                w_seq_pc = n_sp[1] + 32'd4;
                w_load_use = n_sv[2] && (f2.op == OP_LW) &&
                             (n_ex_dest == f1.rs || n_ex_dest == f1.rt);
                if (w_load_use) begin
                    n_stall = 1'b1;
                end else begin
                    n_de_a = (w_wb_we && r_mw_dest == f1.rs) ? r_mw_out : r_rf[f1.rs];
                    n_de_b = (w_wb_we && r_mw_dest == f1.rt) ? r_mw_out : r_rf[f1.rt];
                    if (f1.op == OP_SPECIAL) begin
                        n_de_imm = {27'd0, f1.sh};
                        if (f1.fn == FN_JR) begin
                            w_jump = 1'b1; w_jump_pc = n_de_a;
                        end else begin
                            n_de_dest = f1.rd;
                        end
                    end else begin
                        if (f1.op > OP_BNE && f1.op < OP_SW) n_de_dest = f1.rt;
                        n_de_imm = f1.imm;
                        if (f1.op == OP_JAL) begin
                            w_jal_we = 1'b1; w_jal_data = w_seq_pc;
                        end
                        if (f1.op == OP_J || f1.op == OP_JAL) begin
                            w_jump = 1'b1;
                            w_jump_pc = {w_seq_pc[31:28], f1.tgt, 2'b00};
                        end
                    end
                end
            end

            // Fetch
            w_off = r_pc - TEXT_BASE;
            if (w_flush || (!r_stall && (w_off[31:2] >= {19'd0, r_plen}))) begin
                n_sv[0] = 1'b0; n_sp[0] = '0;
            end else if (!r_stall) begin
                n_sv[0] = 1'b1; n_sp[0] = r_pc;
                n_pc = r_pc + 32'd4;
            end
            if (w_jump) n_pc = w_jump_pc;
            if (w_flush) n_pc = r_ex_target;

            n_fw_ex_reg  = n_ex_dest;
            n_fw_ex_val  = n_ex_alu;
            n_fw_mem_reg = n_mw_dest;
            n_fw_mem_val = n_mw_out;

            // Halt once the last program instruction retires into an empty pipe
            w_off4 = n_sp[4] - TEXT_BASE;
            if (n_sv[3:0] == 4'd0 && n_sv[4] && r_plen != 11'd0 &&
                w_off4[31:2] == ({19'd0, r_plen} - 30'd1)) begin
                n_halted = 1'b1;
            end
            n_out.halted = n_halted;
        end
    end

    // Data memory port selection; the read prefetches the next MEM address
    always_comb begin
        w_dm_we    = 1'b0;
        w_dm_waddr = r_ex_addr[DAW+1:2];
        w_dm_wdata = w_st_data;
        if (r_clr_busy) begin
            w_dm_we = 1'b1; w_dm_waddr = r_clr_idx; w_dm_wdata = '0;
        end else if (w_acc && i_in_data.mode == MODE_DMEM) begin
            w_dm_we = 1'b1; w_dm_waddr = w_ld_didx; w_dm_wdata = i_in_data.word_value;
        end else if (w_st_we) begin
            w_dm_we = 1'b1;
        end
    end
    assign w_dm_raddr = n_ex_addr[DAW+1:2];
    assign w_im_raddr = imem_idx(n_sp[0]);

    always_ff @(posedge i_clk) begin
        if (w_dm_we) r_dmem[w_dm_waddr] <= w_dm_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (w_dm_we && w_dm_waddr == w_dm_raddr) r_dm_rdata <= w_dm_wdata;
        else r_dm_rdata <= r_dmem[w_dm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_im_we) r_imem[w_ld_iidx] <= i_in_data.word_value;
    end

    always_ff @(posedge i_clk) begin
        if (w_im_we && w_ld_iidx == w_im_raddr) r_if_rdata <= i_in_data.word_value;
        else r_if_rdata <= r_imem[w_im_raddr];
    end

    // Register file; a JAL link write in ID wins over write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 32; k++) r_rf[k] <= '0;
        end else begin
            if (w_wb_we && !(w_jal_we && r_mw_dest == REG_RA)) r_rf[r_mw_dest] <= r_mw_out;
            if (w_jal_we) r_rf[REG_RA] <= w_jal_data;
        end
    end

    // Data memory clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == DLAST) r_clr_busy <= 1'b0;
        end
    end

    // Pipeline and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= '0;
            for (int k = 0; k < 5; k++) r_sp[k] <= '0;
            for (int k = 1; k <= 4; k++) r_si[k] <= '0;
            r_pc <= TEXT_BASE;
            r_de_a <= '0; r_de_b <= '0; r_de_imm <= '0; r_de_dest <= '0;
            r_ex_alu <= '0; r_ex_target <= '0; r_ex_addr <= '0;
            r_ex_take <= 1'b0; r_ex_dest <= '0;
            r_mw_dest <= '0; r_mw_out <= '0;
            r_fw_ex_reg <= '0; r_fw_ex_val <= '0; r_fw_mem_reg <= '0; r_fw_mem_val <= '0;
            r_stall <= 1'b0;
            r_halted <= 1'b0;
            r_plen <= '0;
        end else begin
            r_sv <= n_sv;
            r_sp <= n_sp;
            r_si <= n_si;
            r_pc <= n_pc;
            r_de_a <= n_de_a; r_de_b <= n_de_b; r_de_imm <= n_de_imm; r_de_dest <= n_de_dest;
            r_ex_alu <= n_ex_alu; r_ex_target <= n_ex_target; r_ex_addr <= n_ex_addr;
            r_ex_take <= n_ex_take; r_ex_dest <= n_ex_dest;
            r_mw_dest <= n_mw_dest; r_mw_out <= n_mw_out;
            r_fw_ex_reg <= n_fw_ex_reg; r_fw_ex_val <= n_fw_ex_val;
            r_fw_mem_reg <= n_fw_mem_reg; r_fw_mem_val <= n_fw_mem_val;
            r_stall <= n_stall;
            r_halted <= n_halted;
            if (i_cfg_we) r_plen <= i_cfg_wdata;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res) r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### tb/sv/mips_subset_five_stage_pipeline_core_checker.sv
// Checker: watches both channels, predicts each tick's result and compares transactions.
module mips_subset_five_stage_pipeline_core_checker
    import mipsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  t_in         i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  t_out        i_out_data,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    output int          o_fail,
    output int          o_pending,
    output int          o_ticks,
    output int          o_retired,
    output int          o_stores,
    output logic        o_halted
);

    localparam logic [31:0] TEXT_ADDR = 32'h0040_0000;

    // Architectural and pipeline state of the predicted core
    logic [31:0] regs [32];
    logic [31:0] imem [1024];
    logic [31:0] dmem [1024];
    logic [31:0] fetch_pc;
    logic [31:0] spc [5];
    logic        sval [5];
    logic [31:0] de_a, de_b, de_imm;
    logic [4:0]  de_dest;
    logic [31:0] ex_alu, ex_tgt, ex_addr;
    logic        ex_take;
    logic [4:0]  ex_dest;
    logic [4:0]  mw_dest;
    logic [31:0] mw_out;
    logic [4:0]  fwx_reg, fwm_reg;
    logic [31:0] fwx_val, fwm_val;
    logic        hold_if, hold_id, halt_f;
    logic [10:0] plen;

    t_out expected_results[$];
    int   fails, ticks, retired, stores;

    // Field split of the instruction word held at a given pc
    function automatic t_fields crack(input logic [31:0] pc);
        t_fields     f;
        logic [31:0] w;
        logic [31:0] off;
        off = (pc - TEXT_ADDR) >> 2;
        w = imem[off[9:0]];
        f = '0;
        f.op = w[31:26];
        if (f.op == OP_SPECIAL || f.op > OP_JAL) begin
            f.rs = w[25:21];
            f.rt = w[20:16];
            if (f.op == OP_SPECIAL) begin
                f.rd = w[15:11];
                f.sh = w[10:6];
                f.fn = w[5:0];
            end else if (f.op == OP_ANDI || f.op == OP_ORI || f.op == OP_LUI) begin
                f.imm = {16'h0, w[15:0]};
            end else begin
                f.imm = {{16{w[15]}}, w[15:0]};
            end
        end else begin
            f.tgt = w[25:0];
        end
        return f;
    endfunction

    // EX operand with forwarding from the two later latches
    function automatic logic [31:0] pick_operand(input logic [4:0] r, input logic [31:0] latched);
        if (r == 0) return 32'h0;
        if (fwx_reg == r) return fwx_val;
        if (fwm_reg == r) return fwm_val;
        return latched;
    endfunction

    task automatic clear_core();
        for (int k = 0; k < 32; k++) regs[k] = '0;
        for (int k = 0; k < 1024; k++) begin
            imem[k] = '0;
            dmem[k] = '0;
        end
        for (int k = 0; k < 5; k++) begin
            spc[k] = '0;
            sval[k] = 1'b0;
        end
        fetch_pc = TEXT_ADDR;
        de_a = '0; de_b = '0; de_imm = '0; de_dest = '0;
        ex_alu = '0; ex_tgt = '0; ex_addr = '0; ex_take = 1'b0; ex_dest = '0;
        mw_dest = '0; mw_out = '0;
        fwx_reg = '0; fwx_val = '0; fwm_reg = '0; fwm_val = '0;
        hold_if = 1'b0; hold_id = 1'b0; halt_f = 1'b0;
        plen = '0;
    endtask

    // One pipeline clock: returns what the core reports for it
    task automatic advance_pipeline(output t_out r);
        t_fields     f;
        logic        hold, flush, jump_v, branch_v, at_end;
        logic [31:0] jump_pc, br_target, a, b, im, pc, d, off;
        logic [4:0]  sh;
        flush = 1'b0; jump_v = 1'b0; branch_v = 1'b0;
        jump_pc = '0; br_target = '0;
        r = '0;
        if (!halt_f) begin
            for (int i = 3; i >= 0; i--) begin
                if ((i == 0 && hold_if) || (i == 1 && hold_id)) continue;
                spc[i+1] = spc[i];
                sval[i+1] = sval[i];
                spc[i] = '0;
                sval[i] = 1'b0;
            end
            hold = hold_if;
            hold_if = 1'b0;
            hold_id = 1'b0;

            // write back
            if (sval[4]) begin
                f = crack(spc[4]);
                r.retire_valid = 1'b1;
                r.retire_pc = spc[4];
                if (((f.op == OP_SPECIAL && f.fn != FN_JR) || (f.op inside {[6'h06:6'h24]}))
                    && mw_dest != 0)
                    regs[mw_dest] = mw_out;
            end

            // memory
            if (!sval[3]) begin
                mw_dest = '0;
                mw_out = '0;
            end else begin
                f = crack(spc[3]);
                mw_dest = ex_dest;
                mw_out = ex_alu;
                if (ex_take) begin
                    flush = 1'b1;
                    sval[1] = 1'b0; sval[2] = 1'b0;
                    spc[1] = '0; spc[2] = '0;
                    branch_v = 1'b1;
                    br_target = ex_tgt;
                end
                if (f.op == OP_LW) mw_out = dmem[ex_addr[11:2]];
                if (f.op == OP_SW) begin
                    d = '0;
                    if (f.rt != 0) d = (fwm_reg == f.rt) ? fwm_val : regs[f.rt];
                    dmem[ex_addr[11:2]] = d;
                    r.store_valid = 1'b1;
                    r.store_address = ex_addr;
                    r.store_value = d;
                end
            end

            // execute
            if (!sval[2]) begin
                ex_alu = '0; ex_take = 1'b0; ex_tgt = '0; ex_dest = '0; ex_addr = '0;
            end else begin
                pc = spc[2];
                f = crack(pc);
                a = pick_operand(f.rs, de_a);
                b = pick_operand(f.rt, de_b);
                im = de_imm;
                sh = im[4:0];
                ex_take = 1'b0;
                case (f.op)
                    OP_ADDIU: ex_alu = a + im;
                    OP_ANDI:  ex_alu = a & im;
                    OP_LUI:   ex_alu = {im[15:0], 16'h0};
                    OP_ORI:   ex_alu = a | im;
                    OP_SLTIU: ex_alu = (a < im) ? 32'd1 : 32'd0;
                    OP_BEQ: begin
                        ex_tgt = pc + (im << 2) + 32'd4;
                        ex_take = (a == b);
                    end
                    OP_BNE: begin
                        ex_tgt = pc + (im << 2) + 32'd4;
                        ex_take = (a != b);
                    end
                    OP_SPECIAL: begin
                        case (f.fn)
                            FN_SLL:  ex_alu = b << sh;
                            FN_SRL:  ex_alu = b >> sh;
                            FN_JR: begin
                                sval[1] = 1'b0;
                                spc[1] = '0;
                            end
                            FN_ADDU: ex_alu = a + b;
                            FN_SUBU: ex_alu = a - b;
                            FN_AND:  ex_alu = a & b;
                            FN_OR:   ex_alu = a | b;
                            FN_NOR:  ex_alu = ~(a | b);
                            FN_SLTU: ex_alu = (a < b) ? 32'd1 : 32'd0;
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
                // squash the word fetched behind a jump
                if (f.op == OP_J || f.op == OP_JAL) begin
                    sval[1] = 1'b0;
                    spc[1] = '0;
                end
                if (f.op == OP_LW || f.op == OP_SW) ex_addr = a + im;
                ex_dest = de_dest;
            end

            // decode, with the load-use hold
            de_dest = '0;
            if (!sval[1]) begin
                de_a = '0; de_b = '0; de_imm = '0;
            end else begin
                pc = spc[1];
                f = crack(pc);
                if (sval[2] && crack(spc[2]).op == OP_LW && (ex_dest == f.rs || ex_dest == f.rt))
                begin
                    hold_if = 1'b1;
                    hold_id = 1'b1;
                end else begin
                    de_a = regs[f.rs];
                    de_b = regs[f.rt];
                    if (f.op == OP_SPECIAL) begin
                        de_imm = {27'h0, f.sh};
                        if (f.fn == FN_JR) begin
                            jump_v = 1'b1;
                            jump_pc = regs[f.rs];
                        end else begin
                            de_dest = f.rd;
                        end
                    end else begin
                        if (f.op > OP_BNE && f.op < OP_SW) de_dest = f.rt;
                        de_imm = f.imm;
                        if (f.op == OP_JAL) regs[REG_RA] = pc + 32'd4;
                        if (f.op == OP_J || f.op == OP_JAL) begin
                            jump_v = 1'b1;
                            jump_pc = ((pc + 32'd4) & 32'hF000_0000) | {4'h0, f.tgt, 2'b00};
                        end
                    end
                end
            end

            // fetch
            off = (fetch_pc - TEXT_ADDR) >> 2;
            at_end = off >= {21'h0, plen};
            if (flush || (!hold && at_end)) begin
                sval[0] = 1'b0;
                spc[0] = '0;
            end else if (!hold) begin
                sval[0] = 1'b1;
                spc[0] = fetch_pc;
                fetch_pc = fetch_pc + 32'd4;
            end
            if (jump_v) fetch_pc = jump_pc;
            if (branch_v) fetch_pc = br_target;

            fwx_reg = ex_dest;
            fwx_val = ex_alu;
            fwm_reg = mw_dest;
            fwm_val = mw_out;

            off = (spc[4] - TEXT_ADDR) >> 2;
            if (!sval[0] && !sval[1] && !sval[2] && !sval[3] && sval[4] && plen != 0
                && off == {21'h0, plen} - 32'd1)
                halt_f = 1'b1;
        end
        r.halted = halt_f;
    endtask

    task automatic compare_field(input string nm, input logic [31:0] e, input logic [31:0] a);
        if (e !== a) begin
            $display("%0t mismatch %s: expected %h actual %h", $time, nm, e, a);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out r;
        t_out e;
        if (!i_rst_n) begin
            clear_core();
            expected_results.delete();
            fails = 0; ticks = 0; retired = 0; stores = 0;
        end else begin
            if (i_cfg_we) plen = i_cfg_wdata;
            // input transaction
            if (i_in_valid && i_in_ready) begin
                case (i_in_data.mode)
                    MODE_IMEM: imem[i_in_data.word_index] = i_in_data.word_value;
                    MODE_DMEM: dmem[i_in_data.word_index] = i_in_data.word_value;
                    MODE_TICK: begin
                        advance_pipeline(r);
                        expected_results.push_back(r);
                        ticks++;
                    end
                    default: ;
                endcase
            end
            // output transaction
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result: expected none actual %h", $time, i_out_data);
                    fails++;
                end else begin
                    e = expected_results.pop_front();
                    compare_field("retire_valid", e.retire_valid, i_out_data.retire_valid);
                    compare_field("retire_pc", e.retire_pc, i_out_data.retire_pc);
                    compare_field("store_valid", e.store_valid, i_out_data.store_valid);
                    compare_field("store_address", e.store_address, i_out_data.store_address);
                    compare_field("store_value", e.store_value, i_out_data.store_value);
                    compare_field("halted", e.halted, i_out_data.halted);
                    if (e.retire_valid) retired++;
                    if (e.store_valid) stores++;
                end
            end
        end
        o_fail <= fails;
        o_pending <= expected_results.size();
        o_ticks <= ticks;
        o_retired <= retired;
        o_stores <= stores;
        o_halted <= halt_f;
    end

endmodule

### tb/sv/mips_subset_five_stage_pipeline_core_tb.sv
// Testbench top: clock, reset, program stimulus, output stalls and verdict for the core.
module mips_subset_five_stage_pipeline_core_tb;
    import mipsp_pkg::*;

    localparam int WATCH_LIMIT = 6000;
    localparam int PHASES      = 14;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in         in_data;
    logic        out_valid;
    logic        out_ready;
    t_out        out_data;
    logic        cfg_we;
    logic [10:0] cfg_wdata;

    int   fail_count, pending, ticks, retired, stores;
    logic halted_seen;
    bit   calm;
    int   idle_cycles;
    int   stall_left;

    logic [31:0] image [1024];
    int          loop_at [PHASES+1];
    int          pos;

    mips_subset_five_stage_pipeline_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    mips_subset_five_stage_pipeline_core_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_fail      (fail_count),
        .o_pending   (pending),
        .o_ticks     (ticks),
        .o_retired   (retired),
        .o_stores    (stores),
        .o_halted    (halted_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Instruction encoders
    function automatic logic [31:0] enc_r(input logic [4:0] rs, rt, rd, sh, input logic [5:0] fn);
        return {OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs, rt,
                                          input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] enc_j(input logic [5:0] op, input int widx);
        return {op, 26'h10_0000 + 26'(widx)};
    endfunction

    // Register choice biased to a few registers so hazards are frequent
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 31));
        return 5'($urandom_range(0, 7));
    endfunction

    // Random instruction at word index at; control flow lands no further than lim
    function automatic logic [31:0] gen_word(input int at, input int lim, input bit alu_only);
        logic [5:0]  fns [8];
        logic [5:0]  ops [5];
        logic [31:0] w;
        int          kind;
        int          span;
        fns = '{FN_SLL, FN_SRL, FN_ADDU, FN_SUBU, FN_AND, FN_OR, FN_NOR, FN_SLTU};
        ops = '{OP_ADDIU, OP_ANDI, OP_ORI, OP_LUI, OP_SLTIU};
        kind = alu_only ? $urandom_range(0, 9) : $urandom_range(0, 19);
        span = lim - at - 1;
        if (span > 3) span = 3;
        if (kind < 5)
            w = enc_r(pick_reg(), pick_reg(), pick_reg(), 5'($urandom),
                      fns[$urandom_range(0, 7)]);
        else if (kind < 10)
            w = enc_i(ops[$urandom_range(0, 4)], pick_reg(), pick_reg(), 16'($urandom));
        else if (kind < 13)
            w = enc_i(OP_LW, pick_reg(), pick_reg(), 16'($urandom));
        else if (kind < 16)
            w = enc_i(OP_SW, pick_reg(), pick_reg(), 16'($urandom));
        else if (kind < 18)
            w = enc_i($urandom_range(0, 1) ? OP_BEQ : OP_BNE, pick_reg(), pick_reg(),
                      16'($urandom_range(0, span)));
        else if (kind < 19)
            w = enc_j($urandom_range(0, 1) ? OP_J : OP_JAL, $urandom_range(at + 1, lim));
        else begin
            // arbitrary word, kept away from control flow
            w = $urandom;
            if (w[31:26] inside {OP_J, OP_JAL, OP_BEQ, OP_BNE} ||
                (w[31:26] == OP_SPECIAL && w[5:0] == FN_JR))
                w[31:26] = 6'h3f;
        end
        return w;
    endfunction

    task automatic put(input logic [31:0] w);
        image[pos] = w;
        pos++;
    endtask

    // Spin until the phase flag in data memory turns nonzero
    task automatic put_wait_loop(input int ph);
        loop_at[ph] = pos;
        put(enc_i(OP_LW, 5'd0, 5'd1, 16'((1000 + ph) * 4)));
        put(enc_i(OP_BEQ, 5'd1, 5'd0, 16'hfffe));
    endtask

    // One input transaction, with an occasional idle burst before it
    task automatic send(input logic [1:0] mode, input int idx, input logic [31:0] val);
        if (!calm && $urandom_range(0, 9) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= '{mode: mode, word_index: 10'(idx), word_value: val};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
    endtask

    // Ticks with data writes and ignored transactions mixed in
    task automatic run_ticks(input int n);
        repeat (n) begin
            if (!calm && $urandom_range(0, 11) == 0) send(MODE_DMEM, $urandom_range(0, 1023), $urandom);
            if (!calm && $urandom_range(0, 49) == 0) send(2'd3, $urandom_range(0, 1023), $urandom);
            send(MODE_TICK, $urandom_range(0, 1023), $urandom);
        end
    endtask

    // Drain every expected result, then write program_length
    task automatic set_length(input int len);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= 11'(len);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_words(input int lo, input int hi);
        for (int k = lo; k < hi; k++) send(MODE_IMEM, k, image[k]);
    endtask

    // Output side: ready in random runs and stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (calm) begin
            out_ready <= 1'b1;
        end else if ($urandom_range(0, 3) == 0) begin
            out_ready <= 1'b0;
            stall_left <= $urandom_range(1, 19);
        end else begin
            out_ready <= 1'b1;
            stall_left <= $urandom_range(0, 40);
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCH_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", idle_cycles);
                $display("[mips_subset_five_stage_pipeline_core] ERROR");
                $finish;
            end
        end
    end

    initial begin
        int a;
        int len;
        calm = 1'b0;
        idle_cycles = 0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed program: every operation, extreme immediates, hazards
        pos = 0;
        put(enc_i(OP_LUI, 5'd0, 5'd2, 16'hffff));
        put(enc_i(OP_ORI, 5'd2, 5'd2, 16'hffff));
        put(enc_i(OP_ADDIU, 5'd0, 5'd3, 16'hffff));
        put(enc_i(OP_SLTIU, 5'd3, 5'd4, 16'h8000));
        put(enc_i(OP_ANDI, 5'd2, 5'd5, 16'h8001));
        put(enc_i(OP_SW, 5'd0, 5'd2, 16'h0000));
        put(enc_i(OP_LW, 5'd0, 5'd6, 16'h0000));
        put(enc_r(5'd6, 5'd2, 5'd7, 5'd0, FN_ADDU));
        put(enc_r(5'd0, 5'd7, 5'd8, 5'd0, FN_SUBU));
        put(enc_r(5'd8, 5'd3, 5'd9, 5'd0, FN_AND));
        put(enc_r(5'd8, 5'd4, 5'd10, 5'd0, FN_OR));
        put(enc_r(5'd8, 5'd0, 5'd11, 5'd0, FN_NOR));
        put(enc_r(5'd4, 5'd3, 5'd12, 5'd0, FN_SLTU));
        put(enc_r(5'd0, 5'd2, 5'd13, 5'd31, FN_SLL));
        put(enc_r(5'd0, 5'd2, 5'd14, 5'd1, FN_SRL));
        put(enc_i(OP_SW, 5'd3, 5'd14, 16'h7ffc));
        put(enc_i(OP_BEQ, 5'd0, 5'd0, 16'h0001));
        put(enc_i(OP_ADDIU, 5'd0, 5'd20, 16'h0005));
        put(enc_i(OP_BNE, 5'd0, 5'd0, 16'h0001));
        // subroutine call and return through r31
        a = pos;
        put(enc_j(OP_JAL, a + 2));
        put(enc_j(OP_J, a + 4));
        put(enc_i(OP_ADDIU, 5'd31, 5'd21, 16'h0000));
        put(enc_r(5'd31, 5'd0, 5'd0, 5'd0, FN_JR));
        put(32'hfc00_0000);
        put(enc_r(5'd1, 5'd2, 5'd3, 5'd0, 6'h3f));
        put_wait_loop(0);

        // Random blocks, each ending in its own spin loop
        for (int ph = 1; ph <= PHASES; ph++) begin
            len = $urandom_range(12, 30);
            for (int k = 0; k < len; k++) put(gen_word(pos, pos + len - k, 1'b0));
            put_wait_loop(ph);
        end

        // Tail: jump to the top of instruction memory and run off the end
        for (int k = 0; k < 3; k++) put(gen_word(pos, pos + 3, 1'b1));
        put(enc_j(OP_J, 1020));
        for (int k = 0; k < 3; k++) put(32'h0);
        for (int k = 1020; k < 1024; k++) image[k] = gen_word(k, 1023, 1'b1);

        // Empty program: ticks fetch nothing and never halt
        set_length(0);
        run_ticks(4);

        load_words(0, pos);
        load_words(1020, 1024);

        set_length(loop_at[0] + 5);
        run_ticks(80);
        for (int ph = 1; ph <= PHASES; ph++) begin
            set_length(loop_at[ph] + 5);
            send(MODE_DMEM, 1000 + ph - 1, $urandom | 32'h1);
            run_ticks(2 * (loop_at[ph] - loop_at[ph-1]) + 12);
        end

        // Last part without idling: release the final loop and run to the halt
        set_length(1024);
        calm = 1'b1;
        send(MODE_DMEM, 1000 + PHASES, 32'hffff_ffff);
        run_ticks(100);

        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("run: %0d ticks over %0d program phases, %0d retirements, %0d stores, halted=%0b",
                 ticks, PHASES + 2, retired, stores, halted_seen);
        if (fail_count == 0 && pending == 0)
            $display("[mips_subset_five_stage_pipeline_core] OK");
        else
            $display("[mips_subset_five_stage_pipeline_core] ERROR");
        $finish;
    end

endmodule
